// ----- hw/rtl/rbsi_pkg.sv -----
// Shared types and constants of the ray versus box slab test.
package rbsi_pkg;

	localparam int Q_W = 32;
	localparam int FRAC_W = 16;
	// numerator magnitude: 33-bit difference scaled by 2^FRAC_W
	localparam int NUM_W = Q_W + 1 + FRAC_W;
	localparam int DEN_W = Q_W;
	localparam int DIV_STEPS = 4;

	localparam logic signed [Q_W-1:0] Q_MAX = {1'b0, {(Q_W-1){1'b1}}};
	localparam logic signed [Q_W-1:0] Q_MIN = {1'b1, {(Q_W-1){1'b0}}};
	localparam logic signed [Q_W-1:0] MISS_DIST = -(Q_W'(1) <<< FRAC_W);

	typedef logic signed [Q_W-1:0] q_t;

	typedef struct packed {
		q_t box_min_x;
		q_t box_min_y;
		q_t box_min_z;
		q_t box_max_x;
		q_t box_max_y;
		q_t box_max_z;
		q_t origin_x;
		q_t origin_y;
		q_t origin_z;
		q_t direction_x;
		q_t direction_y;
		q_t direction_z;
	} ray_req_t;

	typedef struct packed {
		q_t   hit_distance;
		logic missed;
	} ray_rsp_t;

endpackage

// ----- hw/rtl/rbsi_chan.sv -----
// Valid/ready channel carrying one payload of type T.
interface rbsi_chan #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// ----- hw/rtl/rbsi_div.sv -----
// Pipelined unsigned restoring divider, STEPS quotient bits per stage.
module rbsi_div #(
	parameter int NUM_W = rbsi_pkg::NUM_W,
	parameter int DEN_W = rbsi_pkg::DEN_W,
	parameter int STEPS = rbsi_pkg::DIV_STEPS
) (
	input  logic             clk,
	input  logic             en,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic [NUM_W-1:0] quo
);
	localparam int NSTG = (NUM_W + STEPS - 1) / STEPS;

	// high bits: numerator still to shift in; low bits: quotient so far
	logic [NUM_W-1:0] w_s [0:NSTG];
	logic [DEN_W-1:0] r_s [0:NSTG];
	logic [DEN_W-1:0] d_s [0:NSTG];

	assign w_s[0] = num;
	assign r_s[0] = '0;
	assign d_s[0] = den;

	for (genvar k = 0; k < NSTG; k++) begin : g_stg
		localparam int NB = (NUM_W - k * STEPS < STEPS) ? (NUM_W - k * STEPS) : STEPS;
		logic [NUM_W-1:0] w_n;
		logic [DEN_W-1:0] r_n;

		always_comb begin
			logic [DEN_W:0] rx;
			w_n = w_s[k];
			r_n = r_s[k];
			for (int i = 0; i < NB; i++) begin
				rx = {r_n, w_n[NUM_W-1]};
				w_n = {w_n[NUM_W-2:0], 1'b0};
				if (rx >= {1'b0, d_s[k]}) begin
					rx = rx - {1'b0, d_s[k]};
					w_n[0] = 1'b1;
				end
				r_n = rx[DEN_W-1:0];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				w_s[k+1] <= w_n;
				r_s[k+1] <= r_n;
				d_s[k+1] <= d_s[k];
			end
		end
	end

	assign quo = w_s[NSTG];
endmodule

// ----- hw/rtl/rbsi_slab.sv -----
// One axis: saturate and sign the two plane distances, then order them; a zero direction gives the full range instead.
module rbsi_slab (
	input  logic                      clk,
	input  logic                      en,
	input  logic [rbsi_pkg::NUM_W-1:0] q_lo,
	input  logic [rbsi_pkg::NUM_W-1:0] q_hi,
	input  logic                      neg_lo,
	input  logic                      neg_hi,
	input  logic                      zero,
	input  logic                      between,
	output rbsi_pkg::q_t              enter,
	output rbsi_pkg::q_t              leave,
	output logic                      miss
);
	import rbsi_pkg::*;

	function automatic q_t sat_q(input logic [NUM_W-1:0] q, input logic neg);
		logic big;
		if (neg) begin
			big = (q[NUM_W-1:Q_W] != '0) || (q[Q_W-1] && (q[Q_W-2:0] != '0));
			return big ? Q_MIN : -q[Q_W-1:0];
		end
		big = (q[NUM_W-1:Q_W-1] != '0);
		return big ? Q_MAX : q[Q_W-1:0];
	endfunction

	q_t   a_s1, b_s1;
	logic zero_s1, between_s1;
	q_t   enter_s2, leave_s2;
	logic miss_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1       <= sat_q(q_lo, neg_lo);
			b_s1       <= sat_q(q_hi, neg_hi);
			zero_s1    <= zero;
			between_s1 <= between;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			miss_s2 <= zero_s1 && !between_s1;
			if (zero_s1) begin
				enter_s2 <= Q_MIN;
				leave_s2 <= Q_MAX;
			end else if (a_s1 > b_s1) begin
				enter_s2 <= b_s1;
				leave_s2 <= a_s1;
			end else begin
				enter_s2 <= a_s1;
				leave_s2 <= b_s1;
			end
		end
	end

	assign enter = enter_s2;
	assign leave = leave_s2;
	assign miss  = miss_s2;
endmodule

// ----- hw/rtl/ray_box_slab_intersect.sv -----
// Top level: pipelined ray versus axis-aligned box slab intersection.
//
//  channel | dir | payload
//  req     | in  | ray_req_t: box corners, ray origin, ray direction (Q16.16)
//  rsp     | out | ray_rsp_t: hit_distance (Q16.16), missed
//
// One request enters per cycle while the response is not stalled; its response is
// registered through the input stage, the six pipelined dividers that each resolve
// DIV_STEPS quotient bits per stage, the two slab stages and the two merge stages.
// arst_n clears the valid bits only; data registers hold whatever they had.
// A stalled response freezes the whole pipeline, bubbles included.
module ray_box_slab_intersect #(
	parameter int DIV_STEPS = rbsi_pkg::DIV_STEPS
) (
	input  logic    clk,
	input  logic    arst_n,
	rbsi_chan.sink  req,
	rbsi_chan.source rsp
);
	import rbsi_pkg::*;

	localparam int NSTG = (NUM_W + DIV_STEPS - 1) / DIV_STEPS;
	localparam int LAT  = NSTG + 5;

	typedef struct packed {
		logic [2:0] zero;
		logic [2:0] between;
		logic [5:0] neg;
	} side_t;

	logic           en;
	logic [LAT-1:0] vld_s;

	q_t lo_c [0:2];
	q_t hi_c [0:2];
	q_t org_c [0:2];
	q_t dir_c [0:2];

	logic [NUM_W-1:0] num_c [0:5];
	logic [DEN_W-1:0] den_c [0:2];
	side_t            side_c;

	logic [NUM_W-1:0] num_s1 [0:5];
	logic [DEN_W-1:0] den_s1 [0:2];
	side_t            side_s [0:NSTG];
	logic [NUM_W-1:0] quo [0:5];

	q_t   ent [0:2];
	q_t   lev [0:2];
	logic amiss [0:2];

	q_t       t0_s2, t1_s2;
	logic     miss_s2;
	q_t       ent_z_s2, lev_z_s2;
	logic     miss_z_s2;
	ray_rsp_t rsp_s3;

	assign en        = !vld_s[LAT-1] || rsp.ready;
	assign req.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[LAT-2:0], req.valid};
		end
	end

	assign lo_c[0]  = req.data.box_min_x;
	assign lo_c[1]  = req.data.box_min_y;
	assign lo_c[2]  = req.data.box_min_z;
	assign hi_c[0]  = req.data.box_max_x;
	assign hi_c[1]  = req.data.box_max_y;
	assign hi_c[2]  = req.data.box_max_z;
	assign org_c[0] = req.data.origin_x;
	assign org_c[1] = req.data.origin_y;
	assign org_c[2] = req.data.origin_z;
	assign dir_c[0] = req.data.direction_x;
	assign dir_c[1] = req.data.direction_y;
	assign dir_c[2] = req.data.direction_z;

	// plane - origin at 33 bits, split into magnitude and quotient sign
	always_comb begin
		logic signed [Q_W:0] dl, dh;
		logic [Q_W:0]        ml, mh;
		side_c = '0;
		for (int a = 0; a < 3; a++) begin
			dl = {lo_c[a][Q_W-1], lo_c[a]} - {org_c[a][Q_W-1], org_c[a]};
			dh = {hi_c[a][Q_W-1], hi_c[a]} - {org_c[a][Q_W-1], org_c[a]};
			ml = dl[Q_W] ? -dl : dl;
			mh = dh[Q_W] ? -dh : dh;
			num_c[2*a]   = {ml, {FRAC_W{1'b0}}};
			num_c[2*a+1] = {mh, {FRAC_W{1'b0}}};
			den_c[a] = dir_c[a][Q_W-1] ? -dir_c[a] : dir_c[a];
			side_c.neg[2*a]   = dl[Q_W] ^ dir_c[a][Q_W-1];
			side_c.neg[2*a+1] = dh[Q_W] ^ dir_c[a][Q_W-1];
			side_c.zero[a]    = (dir_c[a] == '0);
			side_c.between[a] = ((lo_c[a] <= org_c[a]) && (org_c[a] <= hi_c[a])) ||
				((hi_c[a] <= org_c[a]) && (org_c[a] <= lo_c[a]));
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_s1    <= num_c;
			den_s1    <= den_c;
			side_s[0] <= side_c;
			for (int k = 0; k < NSTG; k++) begin
				side_s[k+1] <= side_s[k];
			end
		end
	end

	for (genvar q = 0; q < 6; q++) begin : g_div
		rbsi_div #(
			.NUM_W(NUM_W),
			.DEN_W(DEN_W),
			.STEPS(DIV_STEPS)
		) u_div (
			.clk(clk),
			.en (en),
			.num(num_s1[q]),
			.den(den_s1[q/2]),
			.quo(quo[q])
		);
	end

	for (genvar a = 0; a < 3; a++) begin : g_axis
		rbsi_slab u_slab (
			.clk    (clk),
			.en     (en),
			.q_lo   (quo[2*a]),
			.q_hi   (quo[2*a+1]),
			.neg_lo (side_s[NSTG].neg[2*a]),
			.neg_hi (side_s[NSTG].neg[2*a+1]),
			.zero   (side_s[NSTG].zero[a]),
			.between(side_s[NSTG].between[a]),
			.enter  (ent[a]),
			.leave  (lev[a]),
			.miss   (amiss[a])
		);
	end

	// x seeds the interval; y narrows it; hold z one stage to line up
	always_ff @(posedge clk) begin
		if (en) begin
			ent_z_s2  <= ent[2];
			lev_z_s2  <= lev[2];
			miss_z_s2 <= amiss[2];
			if (amiss[0] || amiss[1] || (lev[1] < ent[0]) || (ent[1] > lev[0])) begin
				miss_s2 <= 1'b1;
				t0_s2   <= ent[0];
				t1_s2   <= lev[0];
			end else begin
				miss_s2 <= 1'b0;
				t0_s2   <= (ent[1] > ent[0]) ? ent[1] : ent[0];
				t1_s2   <= (lev[1] < lev[0]) ? lev[1] : lev[0];
			end
		end
	end

	// z narrows once more, then pick the reported distance
	always_ff @(posedge clk) begin
		if (en) begin
			if (miss_s2 || miss_z_s2 || (lev_z_s2 < t0_s2) || (ent_z_s2 > t1_s2)) begin
				rsp_s3.missed       <= 1'b1;
				rsp_s3.hit_distance <= MISS_DIST;
			end else begin
				rsp_s3.missed <= 1'b0;
				if (((ent_z_s2 > t0_s2) ? ent_z_s2 : t0_s2) < 0) begin
					rsp_s3.hit_distance <= (lev_z_s2 < t1_s2) ? lev_z_s2 : t1_s2;
				end else begin
					rsp_s3.hit_distance <= (ent_z_s2 > t0_s2) ? ent_z_s2 : t0_s2;
				end
			end
		end
	end

	assign rsp.valid = vld_s[LAT-1];
	assign rsp.data  = rsp_s3;

	a_miss_dist: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.data.missed |-> rsp.data.hit_distance == MISS_DIST)
		else $error("miss response without miss distance");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(vld_s))
		else $error("valid bits moved during a stall");

	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> vld_s[0])
		else $error("accepted request did not enter the pipeline");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		en && !req.valid |=> !vld_s[0])
		else $error("bubble became valid");
endmodule

// ----- sim/ray_box_slab_intersect_tb.sv -----
// Self-checking testbench for the ray versus box slab intersection pipeline.
`timescale 1ns / 100ps

module ray_box_slab_intersect_tb;
	import rbsi_pkg::*;

	localparam int RAND_ITEMS = 450;
	localparam int TAIL_CYCLES = 40;
	localparam int CYCLE_LIMIT = 200000;
	localparam int LONG_HOLD = 80;
	localparam q_t ONE = 32'sd65536;

	typedef struct {
		ray_req_t ray;
		bit       typed;
		ray_rsp_t hit;
	} ray_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	rbsi_chan #(.T(ray_req_t)) req_ch();
	rbsi_chan #(.T(ray_rsp_t)) rsp_ch();

	ray_box_slab_intersect dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch.sink),
		.rsp(rsp_ch.source)
	);

	ray_rsp_t hits_due[$];
	int errors = 0;
	int cycles = 0;
	int send_gap_max = 3;
	int recv_gap_max = 3;
	bit hold_rsp = 1'b0;

	initial begin
		req_ch.valid = 1'b0;
		req_ch.data = '0;
		rsp_ch.ready = 1'b0;
	end

	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d requests outstanding", $realtime, hits_due.size());
			$display("*** FAILED ***");
			$finish;
		end
	end

	function automatic longint clamp_q(longint v);
		if (v > longint'(Q_MAX))
			return longint'(Q_MAX);
		if (v < longint'(Q_MIN))
			return longint'(Q_MIN);
		return v;
	endfunction

	// Slab test: narrow the x/y/z distance interval, miss as soon as it empties.
	function automatic ray_rsp_t slab_hit(ray_req_t r);
		longint lo[3], hi[3], org[3], dir[3];
		longint t_in, t_out, a, b, t;
		bit gone;
		ray_rsp_t res;
		lo = '{r.box_min_x, r.box_min_y, r.box_min_z};
		hi = '{r.box_max_x, r.box_max_y, r.box_max_z};
		org = '{r.origin_x, r.origin_y, r.origin_z};
		dir = '{r.direction_x, r.direction_y, r.direction_z};
		gone = 1'b0;
		t_in = 0;
		t_out = 0;
		for (int ax = 0; ax < 3 && !gone; ax++) begin
			if (dir[ax] == 0) begin
				a = (lo[ax] < hi[ax]) ? lo[ax] : hi[ax];
				b = (lo[ax] < hi[ax]) ? hi[ax] : lo[ax];
				if (org[ax] < a || org[ax] > b) begin
					gone = 1'b1;
					break;
				end
				a = longint'(Q_MIN);
				b = longint'(Q_MAX);
			end else begin
				a = clamp_q(((lo[ax] - org[ax]) * 65536) / dir[ax]);
				b = clamp_q(((hi[ax] - org[ax]) * 65536) / dir[ax]);
				if (a > b) begin
					t = a;
					a = b;
					b = t;
				end
			end
			if (ax == 0) begin
				t_in = a;
				t_out = b;
			end else if (b < t_in || a > t_out) begin
				gone = 1'b1;
			end else begin
				if (a > t_in)
					t_in = a;
				if (b < t_out)
					t_out = b;
			end
		end
		res.missed = gone;
		res.hit_distance = gone ? MISS_DIST : q_t'(t_in < 0 ? t_out : t_in);
		return res;
	endfunction

	function automatic q_t coord(bit shaped);
		if (shaped)
			return q_t'(int'($urandom_range(0, 2097152)) - 1048576);
		return q_t'($urandom);
	endfunction

	function automatic q_t heading(bit shaped);
		int pick;
		pick = $urandom_range(0, 9);
		if (!shaped)
			return (pick == 0) ? q_t'(0) : q_t'($urandom);
		if (pick < 2)
			return '0;
		if (pick == 2)
			return q_t'(int'($urandom_range(0, 16)) - 8);
		return q_t'(int'($urandom_range(0, 262144)) - 131072);
	endfunction

	function automatic ray_req_t random_ray(bit shaped);
		ray_req_t r;
		q_t a, b;
		q_t lo[3], hi[3];
		for (int ax = 0; ax < 3; ax++) begin
			a = coord(shaped);
			b = coord(shaped);
			// keep most shaped boxes well ordered, a few inverted
			if (shaped && a > b && $urandom_range(0, 7) != 0) begin
				lo[ax] = b;
				hi[ax] = a;
			end else begin
				lo[ax] = a;
				hi[ax] = b;
			end
		end
		r.box_min_x = lo[0];
		r.box_min_y = lo[1];
		r.box_min_z = lo[2];
		r.box_max_x = hi[0];
		r.box_max_y = hi[1];
		r.box_max_z = hi[2];
		r.origin_x = coord(shaped);
		r.origin_y = coord(shaped);
		r.origin_z = coord(shaped);
		r.direction_x = heading(shaped);
		r.direction_y = heading(shaped);
		r.direction_z = heading(shaped);
		return r;
	endfunction

	function automatic ray_req_t make_ray(q_t lx, q_t ly, q_t lz, q_t hx, q_t hy, q_t hz,
			q_t ox, q_t oy, q_t oz, q_t dx, q_t dy, q_t dz);
		return '{lx, ly, lz, hx, hy, hz, ox, oy, oz, dx, dy, dz};
	endfunction

	task automatic send_ray(ray_req_t r, ray_rsp_t hit);
		int gap;
		gap = $urandom_range(0, send_gap_max);
		repeat (gap) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.data <= r;
		do
			@(posedge clk);
		while (!req_ch.ready);
		hits_due.insert(hits_due.size(), hit);
	endtask

	task automatic send_random(int n);
		ray_req_t r;
		repeat (n) begin
			r = random_ray($urandom_range(0, 9) < 8);
			send_ray(r, slab_hit(r));
		end
	endtask

	task automatic drain;
		req_ch.valid <= 1'b0;
		wait (hits_due.size() == 0);
		@(posedge clk);
	endtask

	// Response side: draw a stall per response; hold off long when asked.
	initial begin
		int gap;
		@(posedge arst_n);
		forever begin
			gap = $urandom_range(0, recv_gap_max);
			if (hold_rsp) begin
				gap = LONG_HOLD;
				hold_rsp = 1'b0;
			end
			repeat (gap) begin
				rsp_ch.ready <= 1'b0;
				@(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			do
				@(posedge clk);
			while (!rsp_ch.valid);
		end
	end

	always @(posedge clk) begin
		ray_rsp_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (hits_due.size() == 0) begin
				$display("%0t: unexpected response dist=%0d missed=%0b", $realtime,
					rsp_ch.data.hit_distance, rsp_ch.data.missed);
				errors++;
			end else begin
				want = hits_due.pop_front();
				if (rsp_ch.data.hit_distance !== want.hit_distance) begin
					$display("%0t: hit_distance expected %0d actual %0d", $realtime,
						want.hit_distance, rsp_ch.data.hit_distance);
					errors++;
				end
				if (rsp_ch.data.missed !== want.missed) begin
					$display("%0t: missed expected %0b actual %0b", $realtime,
						want.missed, rsp_ch.data.missed);
					errors++;
				end
			end
		end
	end

	initial begin
		ray_row_t rows[$];
		ray_rsp_t hit;
		ray_rsp_t none;
		none = '0;
		// all directions zero, origin inside: unbounded, report the exit
		rows.insert(rows.size(), '{make_ray(-ONE, -ONE, -ONE, ONE, ONE, ONE, 0, 0, 0, 0, 0, 0),
			1'b1, '{Q_MAX, 1'b0}});
		// zero x direction, origin outside the x planes
		rows.insert(rows.size(),
			'{make_ray(ONE, ONE, ONE, 2 * ONE, 2 * ONE, 2 * ONE, 0, 0, 0, 0, ONE, ONE),
			1'b1, '{MISS_DIST, 1'b1}});
		// zero z direction, origin outside the z planes
		rows.insert(rows.size(),
			'{make_ray(-ONE, -ONE, ONE, ONE, ONE, 2 * ONE, 0, 0, 0, ONE, ONE, 0),
			1'b1, '{MISS_DIST, 1'b1}});
		// plain hit at distance one
		rows.insert(rows.size(),
			'{make_ray(ONE, ONE, ONE, 2 * ONE, 2 * ONE, 2 * ONE, 0, 0, 0, ONE, ONE, ONE),
			1'b1, '{ONE, 1'b0}});
		// origin inside: entry negative, exit reported
		rows.insert(rows.size(),
			'{make_ray(-ONE, -ONE, -ONE, ONE, ONE, ONE, 0, 0, 0, ONE, ONE, ONE),
			1'b0, none});
		// inverted box, negative directions
		rows.insert(rows.size(),
			'{make_ray(2 * ONE, 2 * ONE, 2 * ONE, ONE, ONE, ONE, 0, 0, 0, -ONE, -ONE, -ONE),
			1'b0, none});
		// touching intervals along y
		rows.insert(rows.size(),
			'{make_ray(ONE, 2 * ONE, -ONE, 2 * ONE, 3 * ONE, ONE, 0, 0, 0, ONE, ONE, 0),
			1'b0, none});
		// disjoint y interval
		rows.insert(rows.size(),
			'{make_ray(ONE, 3 * ONE, -ONE, 2 * ONE, 4 * ONE, ONE, 0, 0, 0, ONE, ONE, 0),
			1'b0, none});
		// tiny direction saturates the quotient
		rows.insert(rows.size(),
			'{make_ray(ONE, -ONE, -ONE, 2 * ONE, ONE, ONE, 0, 0, 0, 1, 0, 0),
			1'b0, none});
		rows.insert(rows.size(),
			'{make_ray(Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MIN, 0,
			Q_MIN, Q_MAX, 1), 1'b0, none});
		rows.insert(rows.size(),
			'{make_ray(Q_MAX, Q_MAX, Q_MAX, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MIN,
			Q_MAX, -1, Q_MIN), 1'b0, none});
		rows.insert(rows.size(),
			'{make_ray(Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN,
			0, 0, 0), 1'b0, none});
		rows.insert(rows.size(),
			'{make_ray(Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MIN, Q_MIN, Q_MIN,
			-1, -1, -1), 1'b0, none});
		rows.insert(rows.size(),
			'{make_ray(-1, -1, -1, -1, -1, -1, 0, 0, 0, Q_MAX, Q_MAX, Q_MAX),
			1'b0, none});

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i]) begin
			hit = rows[i].typed ? rows[i].hit : slab_hit(rows[i].ray);
			send_ray(rows[i].ray, hit);
		end
		send_random(RAND_ITEMS / 3);

		// sender pauses until every response is back
		drain();

		// long receiver hold while requests keep coming back to back
		send_gap_max = 0;
		hold_rsp = 1'b1;
		send_random(60);

		// a stretch with no idling on either side
		recv_gap_max = 0;
		send_random(60);
		send_gap_max = 3;
		recv_gap_max = 3;
		send_random(RAND_ITEMS - 2 * (RAND_ITEMS / 3) - 120 + RAND_ITEMS / 3);

		req_ch.valid <= 1'b0;
		wait (hits_due.size() == 0);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (hits_due.size() != 0) begin
			$display("%0t: %0d responses never arrived", $realtime, hits_due.size());
			errors++;
		end
		if (errors == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
